// File: design/aoc_pkg.sv
package aoc_pkg;

	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned NUM_CHAN  = 3;
	localparam int unsigned ALPHA_MAX = 255;
	localparam int unsigned PROD_W    = 2 * CHAN_W;
	localparam int unsigned WIDE_W    = 3 * CHAN_W;
	// quotient stays below 510, so nine bits and a numerator below 2^17
	localparam int unsigned QUOT_W    = 9;
	localparam int unsigned REM_W     = PROD_W + 1;
	localparam int unsigned DIV_FIRST = 3;
	localparam int unsigned NUM_STAGES = DIV_FIRST + QUOT_W + 1;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		chan_t alpha;
		chan_t blue;
		chan_t green;
		chan_t red;
	} pixel_t;

	// exact floor(x / 255) while the quotient fits 16 bits: 2^8 = 1 mod 255, so the base-256 digit sum gives the remainder
	function automatic logic [PROD_W-1:0] div255(input logic [WIDE_W-1:0] x);
		logic [CHAN_W+1:0] s;
		logic [1:0]        c;
		s = {2'b00, x[23:16]} + {2'b00, x[15:8]} + {2'b00, x[7:0]};
		if (s >= 10'(3 * ALPHA_MAX)) begin
			c = 2'd3;
		end else if (s >= 10'(2 * ALPHA_MAX)) begin
			c = 2'd2;
		end else if (s >= 10'(ALPHA_MAX)) begin
			c = 2'd1;
		end else begin
			c = 2'd0;
		end
		return {x[23:16], x[23:16]} + {8'd0, x[15:8]} + {14'd0, c};
	endfunction

endpackage

// File: design/alpha_over_composite.sv
// an input transfer passes through stages 1 to 3, the divider stages and the output stage to reach m_tdata
// throughput: one pixel pair per cycle while the output is not stalled; the per-bit divider stages set the depth
// a stall at the output fills empty stages first, then holds s_tready low
// arst_n clears the stage valid bits only; payload registers are not reset
module alpha_over_composite (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// over_red, over_green, over_blue, over_alpha, under_red, under_green, under_blue, under_alpha
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [31:0] m_tdata
);

	localparam int unsigned NC = aoc_pkg::NUM_CHAN;
	localparam int unsigned NS = aoc_pkg::NUM_STAGES;
	localparam int unsigned QW = aoc_pkg::QUOT_W;
	localparam int unsigned RW = aoc_pkg::REM_W;
	localparam int unsigned DF = aoc_pkg::DIV_FIRST;
	localparam int unsigned PW = aoc_pkg::PROD_W;
	localparam int unsigned WW = aoc_pkg::WIDE_W;

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	assign rdy[NS] = m_tready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NS-1];

	aoc_pkg::pixel_t in_over, in_under;
	assign in_over  = s_tdata[31:0];
	assign in_under = s_tdata[63:32];

	// stage 1: alpha complement and first products
	aoc_pkg::pixel_t over_s1, under_s1;
	aoc_pkg::chan_t  ia_s1;
	logic [aoc_pkg::PROD_W-1:0] pa_s1;
	logic [aoc_pkg::PROD_W-1:0] pu_s1 [NC];
	logic [aoc_pkg::PROD_W-1:0] po_s1 [NC];

	aoc_pkg::chan_t in_ia;
	aoc_pkg::chan_t in_co [NC];
	aoc_pkg::chan_t in_cu [NC];
	assign in_ia    = 8'(aoc_pkg::ALPHA_MAX) - in_over.alpha;
	assign in_co[0] = in_over.red;
	assign in_co[1] = in_over.green;
	assign in_co[2] = in_over.blue;
	assign in_cu[0] = in_under.red;
	assign in_cu[1] = in_under.green;
	assign in_cu[2] = in_under.blue;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			over_s1  <= in_over;
			under_s1 <= in_under;
			ia_s1    <= in_ia;
			pa_s1    <= PW'(in_under.alpha) * PW'(in_ia);
			for (int c = 0; c < NC; c++) begin
				pu_s1[c] <= PW'(in_cu[c]) * PW'(in_under.alpha);
				po_s1[c] <= PW'(in_co[c]) * PW'(in_over.alpha);
			end
		end
	end

	// stage 2: combined alpha, under weight times complement, bypass choice
	aoc_pkg::chan_t  oa_s2;
	logic            byp_s2;
	aoc_pkg::pixel_t pix_s2;
	logic [aoc_pkg::WIDE_W-1:0] wu_s2 [NC];
	logic [aoc_pkg::PROD_W-1:0] po_s2 [NC];

	logic [aoc_pkg::PROD_W-1:0] pa_div;
	aoc_pkg::chan_t             oa_s1;
	logic                       opaque_s1, clear_s1;
	assign pa_div    = aoc_pkg::div255({8'd0, pa_s1});
	assign oa_s1     = over_s1.alpha + pa_div[7:0];
	assign opaque_s1 = over_s1.alpha == 8'(aoc_pkg::ALPHA_MAX);
	assign clear_s1  = over_s1.alpha == 8'd0;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			oa_s2  <= oa_s1;
			byp_s2 <= clear_s1 || opaque_s1 || oa_s1 == 8'd0;
			pix_s2 <= opaque_s1 ? over_s1 : under_s1;
			for (int c = 0; c < NC; c++) begin
				wu_s2[c] <= WW'(pu_s1[c]) * WW'(ia_s1);
				po_s2[c] <= po_s1[c];
			end
		end
	end

	// stage 3: dividend per channel
	aoc_pkg::chan_t  oa_s3;
	logic            byp_s3;
	aoc_pkg::pixel_t pix_s3;
	logic [RW-1:0]   num_s3 [NC];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			oa_s3  <= oa_s2;
			byp_s3 <= byp_s2;
			pix_s3 <= pix_s2;
			for (int c = 0; c < NC; c++) begin
				num_s3[c] <= {1'b0, po_s2[c]} + {1'b0, aoc_pkg::div255(wu_s2[c])};
			end
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	logic [RW-1:0]   dv_rem_s [QW][NC];
	logic [QW-1:0]   dv_q_s   [QW][NC];
	aoc_pkg::chan_t  dv_oa_s  [QW];
	logic            dv_byp_s [QW];
	aoc_pkg::pixel_t dv_pix_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [RW-1:0]   rem_in [NC];
		logic [QW-1:0]   q_in   [NC];
		aoc_pkg::chan_t  oa_in;
		logic            byp_in;
		aoc_pkg::pixel_t pix_in;
		logic [RW-1:0]   trial;

		if (j == 0) begin : g_first
			assign oa_in  = oa_s3;
			assign byp_in = byp_s3;
			assign pix_in = pix_s3;
			always_comb begin
				for (int c = 0; c < NC; c++) begin
					rem_in[c] = num_s3[c];
					q_in[c]   = '0;
				end
			end
		end else begin : g_next
			assign oa_in  = dv_oa_s[j-1];
			assign byp_in = dv_byp_s[j-1];
			assign pix_in = dv_pix_s[j-1];
			always_comb begin
				for (int c = 0; c < NC; c++) begin
					rem_in[c] = dv_rem_s[j-1][c];
					q_in[c]   = dv_q_s[j-1][c];
				end
			end
		end

		assign trial = RW'(oa_in) << (QW - 1 - j);

		always_ff @(posedge clk) begin
			if (rdy[DF+j]) begin
				dv_oa_s[j]  <= oa_in;
				dv_byp_s[j] <= byp_in;
				dv_pix_s[j] <= pix_in;
				for (int c = 0; c < NC; c++) begin
					if (rem_in[c] >= trial) begin
						dv_rem_s[j][c] <= rem_in[c] - trial;
						dv_q_s[j][c]   <= {q_in[c][QW-2:0], 1'b1};
					end else begin
						dv_rem_s[j][c] <= rem_in[c];
						dv_q_s[j][c]   <= {q_in[c][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// output stage: clamp and select
	aoc_pkg::chan_t  clamp [NC];
	aoc_pkg::pixel_t blend;
	aoc_pkg::pixel_t out_s13;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			clamp[c] = dv_q_s[QW-1][c][QW-1] ? 8'(aoc_pkg::ALPHA_MAX) : dv_q_s[QW-1][c][7:0];
		end
		blend.red   = clamp[0];
		blend.green = clamp[1];
		blend.blue  = clamp[2];
		blend.alpha = dv_oa_s[QW-1];
	end

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			out_s13 <= dv_byp_s[QW-1] ? dv_pix_s[QW-1] : blend;
		end
	end

	assign m_tdata = out_s13;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == '1 && !m_tready) |-> !s_tready)
		else $error("input taken while pipeline full and output stalled");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DF+QW-1] && !dv_byp_s[QW-1]) |-> dv_oa_s[QW-1] != 8'd0)
		else $error("blend path divided by zero alpha");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DF+QW-1] && !dv_byp_s[QW-1]) |->
		(dv_rem_s[QW-1][0] < RW'(dv_oa_s[QW-1]) && dv_rem_s[QW-1][1] < RW'(dv_oa_s[QW-1])
		&& dv_rem_s[QW-1][2] < RW'(dv_oa_s[QW-1])))
		else $error("divider remainder not below divisor");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DF+QW-1] && !dv_byp_s[QW-1]) |->
		(dv_q_s[QW-1][0] < 9'd510 && dv_q_s[QW-1][1] < 9'd510 && dv_q_s[QW-1][2] < 9'd510))
		else $error("color quotient out of expected range");

endmodule
